// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define AFRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define AFRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/afrc_pkg.sv
// Types and constants for the audio feedback rate controller.
`timescale 1ns / 1ps
`default_nettype none

package afrc_pkg;

  localparam int BUFFER_WORDS = 1024;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_STOP   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    NUDGE_NONE = 2'd0,
    NUDGE_SLOW = 2'd1,
    NUDGE_FAST = 2'd2
  } nudge_t;

  typedef enum logic {
    CFG_HIGH_SPEED  = 1'b0,
    CFG_RATE_FAMILY = 1'b1
  } cfg_index_t;

  localparam logic [1:0] FAMILY_NONE = 2'd0;
  localparam logic [1:0] FAMILY_88K2 = 2'd1;
  localparam logic [1:0] FAMILY_96K  = 2'd2;

  localparam logic [2:0] WORD_BYTES_NONE = 3'd0;
  localparam logic [2:0] WORD_BYTES_FS   = 3'd3;
  localparam logic [2:0] WORD_BYTES_HS   = 3'd4;

  localparam int STEP_W = 13;
  localparam logic [STEP_W-1:0] STEP_RESET = 13'd256;
  localparam logic [STEP_W-1:0] STEP_CAP   = 13'd4096;
  localparam logic [31:0] COARSE_STEP = 32'd2048;

  localparam logic signed [7:0] DIR_LIMIT = 8'sd120;
  localparam logic signed [7:0] DIR_TURN  = 8'sd7;

  localparam logic [31:0] CLAMP_LIMIT = 32'(98 << 14);
  localparam logic [31:0] RATE_88K2   = 32'((88 << 14) + (1 << 14) / 5);
  localparam logic [31:0] RATE_96K    = 32'(96 << 14);

endpackage

`default_nettype wire

// File: rtl/core/audio_feedback_rate_control.sv
// Audio feedback rate controller: fill gap tracking, adaptive rate nudge, feedback word.
// One transaction per cycle while the output is not stalled. An accepted item lands in
// an input register; a single compute stage then works out the fill gap, nudges the
// 18.14 rate, forms the feedback word, applies the family clamp and loads the result
// register when the output register is empty or being read. The
// controller state (rate, previous gap, nudge direction, direction count, step, LEDs)
// is updated as the item leaves the input register, so consecutive items see the
// state left by the one before. Configuration is read directly by the compute stage.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module audio_feedback_rate_control #(
  parameter int BUFFER_WORDS = afrc_pkg::BUFFER_WORDS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] player_started, [11:1] dma_remaining, [21:12] write_index,
  // [22] buffers_differ, [54:23] load_value, [55] zero
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] feedback_word, [34:32] word_bytes, [66:35] current_rate,
  // [67] slow_indicator, [68] fast_indicator, [71:69] zero
  output logic [71:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data
);

  localparam int GAP_W = $clog2(3 * BUFFER_WORDS + 1);
  localparam logic [GAP_W-1:0] GAP_B  = GAP_W'(BUFFER_WORDS);
  localparam logic [GAP_W-1:0] GAP_2B = GAP_W'(2 * BUFFER_WORDS);
  localparam logic [GAP_W-1:0] GAP_3B = GAP_W'(3 * BUFFER_WORDS);
  localparam logic [GAP_W-1:0] GAP_U2 = GAP_W'(BUFFER_WORDS * 6 / 4);
  localparam logic [GAP_W-1:0] GAP_U1 = GAP_W'(BUFFER_WORDS * 5 / 4);
  localparam logic [GAP_W-1:0] GAP_L1 = GAP_W'(BUFFER_WORDS * 3 / 4);
  localparam logic [GAP_W-1:0] GAP_L2 = GAP_W'(BUFFER_WORDS * 2 / 4);

  // configuration
  logic       high_speed;
  logic [1:0] rate_family;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_speed  <= 1'b0;
      rate_family <= afrc_pkg::FAMILY_NONE;
    end else if (cfg_we) begin
      unique case (afrc_pkg::cfg_index_t'(cfg_index))
        afrc_pkg::CFG_HIGH_SPEED:  high_speed  <= cfg_data[0];
        afrc_pkg::CFG_RATE_FAMILY: rate_family <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic                s1_valid;
  afrc_pkg::opcode_t   s1_opcode;
  logic                s1_started;
  logic [10:0]         s1_remaining;
  logic [9:0]          s1_index;
  logic                s1_differ;
  logic [31:0]         s1_load;
  logic                advance;

  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_opcode    <= afrc_pkg::opcode_t'(s_axis_tuser);
      s1_started   <= s_axis_tdata[0];
      s1_remaining <= s_axis_tdata[11:1];
      s1_index     <= s_axis_tdata[21:12];
      s1_differ    <= s_axis_tdata[22];
      s1_load      <= s_axis_tdata[54:23];
    end
  end

  // controller state
  logic [31:0]                  rate;
  logic [GAP_W-1:0]             previous_gap;
  afrc_pkg::nudge_t             nudge_state;
  logic signed [7:0]            direction_count;
  logic [afrc_pkg::STEP_W-1:0]  step_size;
  logic                         slow_led;
  logic                         fast_led;

  logic [31:0]                  rate_next;
  logic [GAP_W-1:0]             previous_gap_next;
  afrc_pkg::nudge_t             nudge_state_next;
  logic signed [7:0]            direction_count_next;
  logic [afrc_pkg::STEP_W-1:0]  step_size_next;
  logic                         slow_led_next;
  logic                         fast_led_next;
  logic [31:0]                  word_next;
  logic [2:0]                   bytes_next;

  // fill gap
  logic [GAP_W-1:0] rem_sat;
  logic [GAP_W-1:0] idx_sat;
  logic [GAP_W-1:0] fill_sum;
  logic [GAP_W-1:0] gap;

  always_comb begin
    rem_sat  = (32'(s1_remaining) > 32'(BUFFER_WORDS)) ? GAP_B : GAP_W'(s1_remaining);
    idx_sat  = (32'(s1_index) > 32'(BUFFER_WORDS)) ? GAP_B : GAP_W'(s1_index);
    fill_sum = rem_sat + idx_sat;
    if (!s1_differ) begin
      gap = GAP_2B - fill_sum;
    end else if (fill_sum < GAP_B) begin
      gap = GAP_B - fill_sum;
    end else begin
      gap = GAP_3B - fill_sum;
    end
  end

  logic [31:0] rate_adj;
  logic [afrc_pkg::STEP_W-1:0] step_tmp;
  logic signed [7:0] dir_tmp;

  always_comb begin
    rate_adj             = rate;
    step_tmp             = step_size;
    dir_tmp              = direction_count;
    previous_gap_next    = previous_gap;
    nudge_state_next     = nudge_state;
    slow_led_next        = slow_led;
    fast_led_next        = fast_led;
    rate_next            = rate;
    word_next            = '0;
    bytes_next           = afrc_pkg::WORD_BYTES_NONE;

    unique case (s1_opcode)
      afrc_pkg::OP_TICK: begin
        if (s1_started) begin
          previous_gap_next = gap;
          if (gap < previous_gap) begin
            if ((gap < GAP_L1 && nudge_state != afrc_pkg::NUDGE_SLOW) || gap < GAP_L2) begin
              slow_led_next = 1'b1;
              if (gap < GAP_L2) begin
                step_tmp = afrc_pkg::STEP_RESET;
              end
              if (direction_count > 8'sd0) begin
                step_tmp = step_tmp >> 1;
                dir_tmp  = -8'sd1;
              end else if (direction_count > -afrc_pkg::DIR_LIMIT) begin
                dir_tmp = direction_count - 8'sd1;
              end
              if (dir_tmp < -afrc_pkg::DIR_TURN && step_tmp < afrc_pkg::STEP_CAP) begin
                step_tmp = step_tmp << 1;
              end
              rate_adj = rate - (afrc_pkg::COARSE_STEP + 32'(step_tmp));
              nudge_state_next = afrc_pkg::NUDGE_SLOW;
            end else if (gap < GAP_B && nudge_state == afrc_pkg::NUDGE_FAST) begin
              rate_adj         = rate - afrc_pkg::COARSE_STEP;
              slow_led_next    = 1'b0;
              fast_led_next    = 1'b0;
              nudge_state_next = afrc_pkg::NUDGE_NONE;
            end
          end else if (gap > previous_gap) begin
            if ((gap > GAP_U1 && nudge_state != afrc_pkg::NUDGE_FAST) || gap > GAP_U2) begin
              fast_led_next = 1'b1;
              if (gap > GAP_U2) begin
                step_tmp = afrc_pkg::STEP_RESET;
              end
              if (direction_count < 8'sd0) begin
                step_tmp = step_tmp >> 1;
                dir_tmp  = 8'sd1;
              end else if (direction_count < afrc_pkg::DIR_LIMIT) begin
                dir_tmp = direction_count + 8'sd1;
              end
              if (dir_tmp > afrc_pkg::DIR_TURN && step_tmp < afrc_pkg::STEP_CAP) begin
                step_tmp = step_tmp << 1;
              end
              rate_adj = rate + (afrc_pkg::COARSE_STEP + 32'(step_tmp));
              nudge_state_next = afrc_pkg::NUDGE_FAST;
            end else if (gap > GAP_B && nudge_state == afrc_pkg::NUDGE_SLOW) begin
              rate_adj         = rate + afrc_pkg::COARSE_STEP;
              slow_led_next    = 1'b0;
              fast_led_next    = 1'b0;
              nudge_state_next = afrc_pkg::NUDGE_NONE;
            end
          end
        end
        if (high_speed) begin
          word_next  = rate_adj >> 1;
          bytes_next = afrc_pkg::WORD_BYTES_HS;
        end else begin
          word_next  = {8'd0, rate_adj[23:0]};
          bytes_next = afrc_pkg::WORD_BYTES_FS;
        end
        rate_next = rate_adj;
        if (s1_started && rate_adj > afrc_pkg::CLAMP_LIMIT) begin
          case (rate_family)
            afrc_pkg::FAMILY_88K2: rate_next = afrc_pkg::RATE_88K2;
            afrc_pkg::FAMILY_96K:  rate_next = afrc_pkg::RATE_96K;
            default:               rate_next = rate_adj;
          endcase
        end
      end
      afrc_pkg::OP_LOAD: begin
        rate_next = s1_load;
      end
      afrc_pkg::OP_STOP: begin
        previous_gap_next = GAP_B;
      end
      default: ;
    endcase

    step_size_next       = step_tmp;
    direction_count_next = dir_tmp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate            <= '0;
      previous_gap    <= GAP_B;
      nudge_state     <= afrc_pkg::NUDGE_NONE;
      direction_count <= '0;
      step_size       <= afrc_pkg::STEP_RESET;
      slow_led        <= 1'b0;
      fast_led        <= 1'b0;
    end else if (advance) begin
      rate            <= rate_next;
      previous_gap    <= previous_gap_next;
      nudge_state     <= nudge_state_next;
      direction_count <= direction_count_next;
      step_size       <= step_size_next;
      slow_led        <= slow_led_next;
      fast_led        <= fast_led_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {3'd0, fast_led_next, slow_led_next, rate_next, bytes_next, word_next};
    end
  end

  `AFRC_ASSERT(a_step_shape,
    ($countones(step_size) <= 1) && (step_size <= afrc_pkg::STEP_CAP),
    "step size not a power of two within cap")
  `AFRC_ASSERT(a_dir_range,
    (direction_count <= afrc_pkg::DIR_LIMIT) && (direction_count >= -afrc_pkg::DIR_LIMIT),
    "direction count out of range")
  `AFRC_ASSERT(a_nudge_led,
    ((nudge_state != afrc_pkg::NUDGE_FAST) || fast_led) &&
    ((nudge_state != afrc_pkg::NUDGE_SLOW) || slow_led),
    "nudge direction without its LED")
  `AFRC_ASSERT(a_gap_range, previous_gap <= GAP_3B, "previous gap beyond three buffers")
  `AFRC_ASSERT(a_stall_cause, !s_axis_tready |-> (s1_valid && m_axis_tvalid && !m_axis_tready),
    "input stalled without a full pipe")

endmodule

`default_nettype wire

// File: tb/tb_audio_feedback_rate_control.sv
// Self-checking testbench for the audio feedback rate controller stream interface.
`timescale 1ns / 1ps

module tb_audio_feedback_rate_control;
  import afrc_pkg::*;

  localparam int GAP_L2 = BUFFER_WORDS * 2 / 4;
  localparam int GAP_L1 = BUFFER_WORDS * 3 / 4;
  localparam int GAP_U1 = BUFFER_WORDS * 5 / 4;
  localparam int GAP_U2 = BUFFER_WORDS * 6 / 4;
  localparam logic [1:0] FAMILY_SPARE = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 64;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    opcode_t     op;
    logic        started;
    logic [10:0] rem;
    logic [9:0]  idx;
    logic        differ;
    logic [31:0] load;
  } stim_t;

  // Declared MSB first so it maps straight onto m_axis_tdata[68:0].
  typedef struct packed {
    logic        fast;
    logic        slow;
    logic [31:0] rate;
    logic [2:0]  bytes;
    logic [31:0] word;
  } fb_result_t;

  typedef struct packed {
    stim_t      item;
    logic       typed;
    fb_result_t want;
  } dir_row_t;

  localparam fb_result_t NO_RES = '0;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [1:0]  cfg_data;

  // Rate controller mirror
  logic [31:0] fb_rate = '0;
  int          last_gap = BUFFER_WORDS;
  nudge_t      nudge_dir = NUDGE_NONE;
  int          trend_count = 0;
  logic [12:0] step_q = STEP_RESET;
  logic        slow_q = 1'b0;
  logic        fast_q = 1'b0;
  logic        cfg_hs = 1'b0;
  logic [1:0]  cfg_family = FAMILY_NONE;

  fb_result_t  expected_results[$];
  int          errors = 0;
  logic        hold_off = 1'b0;
  int          walk_gap = BUFFER_WORDS;
  int          walk_dir = 1;

  logic [1:0]  family_seq [PHASES] = '{FAMILY_88K2, FAMILY_96K, FAMILY_SPARE,
                                       FAMILY_NONE, FAMILY_96K, FAMILY_88K2};

  dir_row_t plan [25] = '{
    '{'{OP_TICK,   1'b0, 11'd0,    10'd0,    1'b0, 32'h0}, 1'b1,
      '{1'b0, 1'b0, 32'h0, WORD_BYTES_FS, 32'h0}},
    '{'{OP_LOAD,   1'b0, 11'd0,    10'd0,    1'b0, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 1'b0, 32'hFFFF_FFFF, WORD_BYTES_NONE, 32'h0}},
    '{'{OP_TICK,   1'b0, 11'd2047, 10'd1023, 1'b1, 32'h0}, 1'b1,
      '{1'b0, 1'b0, 32'hFFFF_FFFF, WORD_BYTES_FS, 32'h00FF_FFFF}},
    '{'{OP_UNUSED, 1'b1, 11'd2047, 10'd1023, 1'b1, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 1'b0, 32'hFFFF_FFFF, WORD_BYTES_NONE, 32'h0}},
    '{'{OP_LOAD,   1'b1, 11'd0,    10'd0,    1'b0, 32'h0}, 1'b1,
      '{1'b0, 1'b0, 32'h0, WORD_BYTES_NONE, 32'h0}},
    // rate wraps below zero on the slow move
    '{'{OP_TICK,   1'b1, 11'd2047, 10'd1023, 1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd0,    10'd0,    1'b1, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd0,    10'd0,    1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_STOP,   1'b1, 11'd1024, 10'd512,  1'b1, 32'h1234_5678}, 1'b0, NO_RES},
    '{'{OP_LOAD,   1'b0, 11'd0,    10'd0,    1'b0, RATE_96K}, 1'b0, NO_RES},
    // alternating reversals walk the step down to zero
    '{'{OP_TICK,   1'b1, 11'd748,  10'd600,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd248,  10'd500,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd748,  10'd600,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd248,  10'd500,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd748,  10'd600,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd248,  10'd500,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd748,  10'd600,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd248,  10'd500,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd748,  10'd600,  1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd248,  10'd500,  1'b0, 32'h0}, 1'b0, NO_RES},
    // deep slow move reloads the step, then a release
    '{'{OP_TICK,   1'b1, 11'd900,  10'd24,   1'b1, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b1, 11'd1024, 10'd1023, 1'b1, 32'h0}, 1'b0, NO_RES},
    '{'{OP_TICK,   1'b0, 11'd1500, 10'd7,    1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_UNUSED, 1'b0, 11'd0,    10'd0,    1'b0, 32'h0}, 1'b0, NO_RES},
    '{'{OP_STOP,   1'b0, 11'd0,    10'd0,    1'b0, 32'h0}, 1'b0, NO_RES}
  };

  audio_feedback_rate_control dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_between(logic [10:0] rem, logic [9:0] idx, logic differ);
    int r;
    int i;
    r = (rem > BUFFER_WORDS) ? BUFFER_WORDS : int'(rem);
    i = (idx > BUFFER_WORDS) ? BUFFER_WORDS : int'(idx);
    if (!differ) return 2 * BUFFER_WORDS - i - r;
    if (i < BUFFER_WORDS - r) return BUFFER_WORDS - r - i;
    return 3 * BUFFER_WORDS - i - r;
  endfunction

  function automatic void nudge_rate(int gap);
    if (gap < last_gap) begin
      if ((gap < GAP_L1 && nudge_dir != NUDGE_SLOW) || gap < GAP_L2) begin
        fb_rate -= COARSE_STEP;
        slow_q = 1'b1;
        if (gap < GAP_L2) step_q = STEP_RESET;
        if (trend_count > 0) begin
          step_q >>= 1;
          trend_count = -1;
        end else if (trend_count > -int'(DIR_LIMIT)) begin
          trend_count--;
        end
        if (trend_count < -int'(DIR_TURN) && step_q < STEP_CAP) step_q <<= 1;
        fb_rate -= 32'(step_q);
        nudge_dir = NUDGE_SLOW;
      end else if (gap < BUFFER_WORDS && nudge_dir == NUDGE_FAST) begin
        fb_rate -= COARSE_STEP;
        slow_q = 1'b0;
        fast_q = 1'b0;
        nudge_dir = NUDGE_NONE;
      end
    end else if (gap > last_gap) begin
      if ((gap > GAP_U1 && nudge_dir != NUDGE_FAST) || gap > GAP_U2) begin
        fb_rate += COARSE_STEP;
        fast_q = 1'b1;
        if (gap > GAP_U2) step_q = STEP_RESET;
        if (trend_count < 0) begin
          step_q >>= 1;
          trend_count = 1;
        end else if (trend_count < int'(DIR_LIMIT)) begin
          trend_count++;
        end
        if (trend_count > int'(DIR_TURN) && step_q < STEP_CAP) step_q <<= 1;
        fb_rate += 32'(step_q);
        nudge_dir = NUDGE_FAST;
      end else if (gap > BUFFER_WORDS && nudge_dir == NUDGE_SLOW) begin
        fb_rate += COARSE_STEP;
        slow_q = 1'b0;
        fast_q = 1'b0;
        nudge_dir = NUDGE_NONE;
      end
    end
    last_gap = gap;
  endfunction

  function automatic fb_result_t predict_feedback(stim_t it);
    fb_result_t res;
    res = '0;
    case (it.op)
      OP_TICK: begin
        if (it.started) nudge_rate(gap_between(it.rem, it.idx, it.differ));
        if (cfg_hs) begin
          res.word  = fb_rate >> 1;
          res.bytes = WORD_BYTES_HS;
        end else begin
          res.word  = {8'h00, fb_rate[23:0]};
          res.bytes = WORD_BYTES_FS;
        end
        if (it.started) begin
          if (cfg_family == FAMILY_88K2 && fb_rate > CLAMP_LIMIT) fb_rate = RATE_88K2;
          else if (cfg_family == FAMILY_96K && fb_rate > CLAMP_LIMIT) fb_rate = RATE_96K;
        end
      end
      OP_LOAD: fb_rate = it.load;
      OP_STOP: last_gap = BUFFER_WORDS;
      default: ;
    endcase
    res.rate = fb_rate;
    res.slow = slow_q;
    res.fast = fast_q;
    return res;
  endfunction

  // Mostly a drifting fill gap fed as consistent ticks, with loads, stops and noise mixed in.
  function automatic stim_t make_item();
    stim_t it;
    int pick;
    int s;
    int lo;
    int hi;
    int idx_v;
    it.op      = OP_TICK;
    it.started = 1'($urandom);
    it.rem     = 11'($urandom);
    it.idx     = 10'($urandom);
    it.differ  = 1'($urandom);
    it.load    = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < 6) begin
      it.op = OP_LOAD;
      case ($urandom_range(3, 0))
        0: ;
        1: it.load = CLAMP_LIMIT - 32'd16384 + 32'($urandom_range(32768, 0));
        2: it.load = RATE_88K2 - 32'd8192 + 32'($urandom_range(16384, 0));
        default: it.load = RATE_96K - 32'd8192 + 32'($urandom_range(16384, 0));
      endcase
    end else if (pick < 9) begin
      it.op = OP_STOP;
    end else if (pick < 11) begin
      it.op = OP_UNUSED;
    end else if (pick < 16) begin
      it.started = 1'b0;
    end else if (pick < 24) begin
      it.started = 1'b1;
    end else begin
      it.started = 1'b1;
      if ($urandom_range(11, 0) == 0) walk_dir = -walk_dir;
      walk_gap += walk_dir * int'($urandom_range(40, 1));
      if (walk_gap < 1) begin
        walk_gap = 1;
        walk_dir = 1;
      end else if (walk_gap > 2 * BUFFER_WORDS - 1) begin
        walk_gap = 2 * BUFFER_WORDS - 1;
        walk_dir = -1;
      end
      if (walk_gap < BUFFER_WORDS && $urandom_range(1, 0) == 1) begin
        it.differ = 1'b1;
        s = BUFFER_WORDS - walk_gap;
      end else if (walk_gap > BUFFER_WORDS && $urandom_range(1, 0) == 1) begin
        it.differ = 1'b1;
        s = 3 * BUFFER_WORDS - walk_gap;
      end else begin
        it.differ = 1'b0;
        s = 2 * BUFFER_WORDS - walk_gap;
      end
      lo = (s > BUFFER_WORDS) ? s - BUFFER_WORDS : 0;
      hi = (s < BUFFER_WORDS - 1) ? s : BUFFER_WORDS - 1;
      idx_v = $urandom_range(hi, lo);
      it.idx = 10'(idx_v);
      it.rem = 11'(s - idx_v);
      if (s - idx_v == BUFFER_WORDS && $urandom_range(1, 0) == 1)
        it.rem = 11'($urandom_range(2047, BUFFER_WORDS));
    end
    return it;
  endfunction

  function automatic int send_gap();
    int k;
    k = $urandom_range(99, 0);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic offer(input stim_t it, input logic typed, input fb_result_t want);
    fb_result_t pred;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.load, it.differ, it.idx, it.rem, it.started};
    s_axis_tuser  <= it.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = predict_feedback(it);
    expected_results.push_back(typed ? want : pred);
  endtask

  task automatic pause_send(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input logic [1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_HIGH_SPEED) cfg_hs = val[0];
    else cfg_family = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    fb_result_t want;
    fb_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[68:0];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("feedback_word", want.word, got.word);
        check_field("word_bytes", 32'(want.bytes), 32'(got.bytes));
        check_field("current_rate", want.rate, got.rate);
        check_field("slow_indicator", 32'(want.slow), 32'(got.slow));
        check_field("fast_indicator", 32'(want.fast), 32'(got.fast));
      end
    end
  end

  initial begin : sink_pacing
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        m_axis_tready <= 1'b1;
        run_left--;
      end else begin
        run_left = $urandom_range(30, 0);
        stall_left = ($urandom_range(99, 0) < 80) ? $urandom_range(3, 1)
                                                 : $urandom_range(60, 10);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_TICK;
    cfg_we = 1'b0;
    cfg_index = CFG_HIGH_SPEED;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      offer(plan[k].item, plan[k].typed, plan[k].want);
      pause_send(send_gap());
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_cfg(CFG_HIGH_SPEED, {1'b0, ph % 2 == 0});
      write_cfg(CFG_RATE_FAMILY, family_seq[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        offer(make_item(), 1'b0, NO_RES);
        if (ph == 0 && n == 8) hold_off = 1'b1;
        if (ph % 2 == 1 && n == PHASE_ITEMS / 2) settle();
        else pause_send(hold_off ? 0 : send_gap());
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
